@@ sv/rpp_pkg.sv @@
`timescale 1ns / 1ps
// Package for rotate_project_point: register codes, reset values, fixed widths
// and shared structs. No dependencies.
package rpp_pkg;

  localparam int COORD_W = 18;
  localparam int TRIG_W  = 16;
  localparam int SCR_W   = 16;
  localparam int PIX_W   = 12;
  localparam int IDX_W   = 3;
  // quotient bits per lane: top bit flags |q| >= 2^(QW-1), which always clamps
  localparam int QW      = 19;

  localparam logic [IDX_W-1:0] REG_SIN_A    = 3'd0;
  localparam logic [IDX_W-1:0] REG_COS_A    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SIN_B    = 3'd2;
  localparam logic [IDX_W-1:0] REG_COS_B    = 3'd3;
  localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd5;
  localparam logic [IDX_W-1:0] REG_FOCAL    = 3'd6;
  localparam logic [IDX_W-1:0] REG_EYE      = 3'd7;

  localparam logic signed [TRIG_W-1:0] RST_SIN = 16'sd0;
  localparam logic signed [TRIG_W-1:0] RST_COS = 16'sd16384;
  localparam logic [PIX_W-1:0] RST_CENTER_X = 12'd320;
  localparam logic [PIX_W-1:0] RST_CENTER_Y = 12'd240;
  localparam logic [PIX_W-1:0] RST_FOCAL    = 12'd1000;
  localparam logic [PIX_W-1:0] RST_EYE      = 12'd1400;

  localparam int SCR_MAX = 32767;
  localparam int SCR_MIN = -32768;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_a;
    logic signed [TRIG_W-1:0] cos_a;
    logic signed [TRIG_W-1:0] sin_b;
    logic signed [TRIG_W-1:0] cos_b;
    logic [PIX_W-1:0]         center_x;
    logic [PIX_W-1:0]         center_y;
    logic [PIX_W-1:0]         focal_length;
    logic [PIX_W-1:0]         eye_distance;
  } rpp_regs_t;

  typedef struct packed {
    logic behind;
    logic neg_y;
    logic neg_z;
  } rpp_flags_t;

endpackage

@@ sv/rpp_ifs.sv @@
`timescale 1ns / 1ps
// Channel interfaces for rotate_project_point: point input, screen result,
// register write port. Depends on nothing.
interface rpp_point_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] pos_x;
  logic signed [17:0] pos_y;
  logic signed [17:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface rpp_screen_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic               behind_eye;
  logic               saturated;
  modport source (output valid, screen_x, screen_y, behind_eye, saturated, input ready);
  modport sink   (input valid, screen_x, screen_y, behind_eye, saturated, output ready);
endinterface

interface rpp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/rpp_rotate.sv @@
`timescale 1ns / 1ps
// Front end: two rotations, eye-distance denominator and projection numerators,
// ending in magnitudes for the divider row. Uses rpp_pkg.
module rpp_rotate #(
  parameter int FRAC = 8,
  parameter int DENW = 54,
  parameter int NUMW = 65
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rpp_pkg::rpp_regs_t       regs,
  input  logic                     v_in,
  output logic                     go_out,
  input  logic signed [17:0]       pos_x,
  input  logic signed [17:0]       pos_y,
  input  logic signed [17:0]       pos_z,
  output logic                     v_out,
  input  logic                     go_in,
  output logic [DENW-1:0]          den_mag,
  output logic [NUMW-1:0]          mag_y,
  output logic [NUMW-1:0]          mag_z,
  output rpp_pkg::rpp_flags_t      flags
);
  import rpp_pkg::*;

  localparam int PW  = 34;
  localparam int S1W = 35;
  localparam int S2W = 52;

  logic [3:0] v;
  logic [3:0] go;

  assign go[3]  = !v[3] || go_in;
  assign go[2]  = !v[2] || go[3];
  assign go[1]  = !v[1] || go[2];
  assign go[0]  = !v[0] || go[1];
  assign go_out = go[0];
  assign v_out  = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) v[0] <= v_in;
      if (go[1]) v[1] <= v[0];
      if (go[2]) v[2] <= v[1];
      if (go[3]) v[3] <= v[2];
    end
  end

  // stage A: first rotation
  logic signed [PW-1:0]  m_xc, m_ys, m_yc, m_xs, m_zs, m_zc;
  logic signed [S1W-1:0] x1, y1;
  logic signed [PW-1:0]  pzs, pzc;

  assign m_xc = PW'(pos_x) * PW'(regs.cos_a);
  assign m_ys = PW'(pos_y) * PW'(regs.sin_a);
  assign m_yc = PW'(pos_y) * PW'(regs.cos_a);
  assign m_xs = PW'(pos_x) * PW'(regs.sin_a);
  assign m_zs = PW'(pos_z) * PW'(regs.sin_b);
  assign m_zc = PW'(pos_z) * PW'(regs.cos_b);

  always_ff @(posedge clk) begin
    if (go[0] && v_in) begin
      x1  <= S1W'(m_xc) + S1W'(m_ys);
      y1  <= S1W'(m_yc) - S1W'(m_xs);
      pzs <= m_zs;
      pzc <= m_zc;
    end
  end

  // stage B: second rotation, all at scale 2^(F+28)
  logic signed [S2W-1:0] t_xc, t_xs, x2, z2, y2;

  assign t_xc = S2W'(x1) * S2W'(regs.cos_b);
  assign t_xs = S2W'(x1) * S2W'(regs.sin_b);

  always_ff @(posedge clk) begin
    if (go[1] && v[0]) begin
      x2 <= t_xc - (S2W'(pzs) <<< 14);
      z2 <= (S2W'(pzc) <<< 14) + t_xs;
      y2 <= S2W'(y1) <<< 14;
    end
  end

  // stage C: denominator and numerators
  logic signed [DENW-1:0] eye_s, den;
  logic signed [NUMW-1:0] foc_s, num_y, num_z;

  assign eye_s = DENW'($signed({1'b0, regs.eye_distance})) <<< (FRAC + 28);
  assign foc_s = NUMW'($signed({1'b0, regs.focal_length}));

  always_ff @(posedge clk) begin
    if (go[2] && v[1]) begin
      den   <= eye_s - DENW'(x2);
      num_y <= foc_s * NUMW'(y2);
      num_z <= foc_s * NUMW'(z2);
    end
  end

  // stage D: sign/magnitude split
  always_ff @(posedge clk) begin
    if (go[3] && v[2]) begin
      den_mag      <= den;
      mag_y        <= num_y[NUMW-1] ? NUMW'(-num_y) : num_y;
      mag_z        <= num_z[NUMW-1] ? NUMW'(-num_z) : num_z;
      flags.behind <= den[DENW-1] || (den == '0);
      flags.neg_y  <= num_y[NUMW-1];
      flags.neg_z  <= num_z[NUMW-1];
    end
  end

endmodule

@@ sv/rpp_div_cell.sv @@
`timescale 1ns / 1ps
// One restoring-division cell: decides one quotient bit for both lanes against
// the shared denominator and passes the partial remainders on. Uses rpp_pkg.
module rpp_div_cell #(
  parameter int CW   = 73,
  parameter int DENW = 54,
  parameter int BIT  = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      v_in,
  output logic                      go_out,
  input  logic [DENW-1:0]           den_in,
  input  logic [CW-1:0]             ry_in,
  input  logic [CW-1:0]             rz_in,
  input  logic [rpp_pkg::QW-1:0]    qy_in,
  input  logic [rpp_pkg::QW-1:0]    qz_in,
  input  rpp_pkg::rpp_flags_t       fl_in,
  output logic                      v_out,
  input  logic                      go_in,
  output logic [DENW-1:0]           den_out,
  output logic [CW-1:0]             ry_out,
  output logic [CW-1:0]             rz_out,
  output logic [rpp_pkg::QW-1:0]    qy_out,
  output logic [rpp_pkg::QW-1:0]    qz_out,
  output rpp_pkg::rpp_flags_t       fl_out
);
  import rpp_pkg::*;

  logic [CW-1:0] dsh;
  logic          by, bz;

  assign dsh    = CW'(den_in) << BIT;
  assign by     = ry_in >= dsh;
  assign bz     = rz_in >= dsh;
  assign go_out = !v_out || go_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (go_out) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (go_out && v_in) begin
      den_out <= den_in;
      ry_out  <= by ? ry_in - dsh : ry_in;
      rz_out  <= bz ? rz_in - dsh : rz_in;
      qy_out  <= {qy_in[QW-2:0], by};
      qz_out  <= {qz_in[QW-2:0], bz};
      fl_out  <= fl_in;
    end
  end

endmodule

@@ sv/rotate_project_point.sv @@
`timescale 1ns / 1ps
// Top level of rotate_project_point: registers, front end, divider row, output.
// Uses rpp_pkg, rpp_ifs, rpp_rotate and rpp_div_cell.
//
// Takes one point per cycle while the output is not stalled and returns one screen
// result per point, in order: 4 front-end stages (rotations, denominator and
// numerators, magnitudes), a row of 19 divider cells that each settle one quotient
// bit for both screen axes, and the output register with centering and clamping.
// Stalls fill empty stages first, so the input keeps accepting while a result
// waits, until the stages are full. Register writes are taken at any cycle (ready
// is always high) and should be made only while the block is idle.
module rotate_project_point #(
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  rpp_point_if.sink           point,
  rpp_screen_if.source        screen,
  rpp_cfg_if.sink             cfg
);
  import rpp_pkg::*;

  localparam int S2W  = 52;
  localparam int EYEW = COORD_FRAC_BITS + 41;
  localparam int DENW = ((EYEW > S2W) ? EYEW : S2W) + 2;
  localparam int NUMW = S2W + 13;
  localparam int CW   = ((NUMW > DENW + QW - 1) ? NUMW : DENW + QW - 1) + 1;

  // registers
  rpp_regs_t regs;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sin_a        <= RST_SIN;
      regs.cos_a        <= RST_COS;
      regs.sin_b        <= RST_SIN;
      regs.cos_b        <= RST_COS;
      regs.center_x     <= RST_CENTER_X;
      regs.center_y     <= RST_CENTER_Y;
      regs.focal_length <= RST_FOCAL;
      regs.eye_distance <= RST_EYE;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SIN_A:    regs.sin_a        <= cfg.data;
        REG_COS_A:    regs.cos_a        <= cfg.data;
        REG_SIN_B:    regs.sin_b        <= cfg.data;
        REG_COS_B:    regs.cos_b        <= cfg.data;
        REG_CENTER_X: regs.center_x     <= cfg.data[PIX_W-1:0];
        REG_CENTER_Y: regs.center_y     <= cfg.data[PIX_W-1:0];
        REG_FOCAL:    regs.focal_length <= cfg.data[PIX_W-1:0];
        REG_EYE:      regs.eye_distance <= cfg.data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // chain wiring: index 0 is the front end output
  logic             cv   [QW+1];
  logic             cgo  [QW+1];
  logic [DENW-1:0]  cden [QW+1];
  logic [CW-1:0]    cry  [QW+1];
  logic [CW-1:0]    crz  [QW+1];
  logic [QW-1:0]    cqy  [QW+1];
  logic [QW-1:0]    cqz  [QW+1];
  rpp_flags_t       cfl  [QW+1];
  logic [NUMW-1:0]  mag_y, mag_z;
  logic             out_go;

  rpp_rotate #(.FRAC(COORD_FRAC_BITS), .DENW(DENW), .NUMW(NUMW)) u_rot (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .v_in    (point.valid),
    .go_out  (point.ready),
    .pos_x   (point.pos_x),
    .pos_y   (point.pos_y),
    .pos_z   (point.pos_z),
    .v_out   (cv[0]),
    .go_in   (cgo[0]),
    .den_mag (cden[0]),
    .mag_y   (mag_y),
    .mag_z   (mag_z),
    .flags   (cfl[0])
  );

  assign cry[0] = CW'(mag_y);
  assign crz[0] = CW'(mag_z);
  assign cqy[0] = '0;
  assign cqz[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    rpp_div_cell #(.CW(CW), .DENW(DENW), .BIT(QW - 1 - i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .v_in    (cv[i]),
      .go_out  (cgo[i]),
      .den_in  (cden[i]),
      .ry_in   (cry[i]),
      .rz_in   (crz[i]),
      .qy_in   (cqy[i]),
      .qz_in   (cqz[i]),
      .fl_in   (cfl[i]),
      .v_out   (cv[i+1]),
      .go_in   (cgo[i+1]),
      .den_out (cden[i+1]),
      .ry_out  (cry[i+1]),
      .rz_out  (crz[i+1]),
      .qy_out  (cqy[i+1]),
      .qz_out  (cqz[i+1]),
      .fl_out  (cfl[i+1])
    );
  end

  assign out_go   = !screen.valid || screen.ready;
  assign cgo[QW]  = out_go;

  // centering and clamping; top quotient bit means the value clamps
  logic [QW-1:0]         qy, qz;
  rpp_flags_t            fl;
  logic signed [QW:0]    sqy, sqz;
  logic signed [QW+1:0]  sum_x, sum_y;
  logic signed [SCR_W-1:0] sx_next, sy_next;
  logic                  satx, saty;

  assign qy = cqy[QW];
  assign qz = cqz[QW];
  assign fl = cfl[QW];
  assign sqy = fl.neg_y ? -$signed({2'b00, qy[QW-2:0]}) : $signed({2'b00, qy[QW-2:0]});
  assign sqz = fl.neg_z ? -$signed({2'b00, qz[QW-2:0]}) : $signed({2'b00, qz[QW-2:0]});
  assign sum_x = $signed({{(QW+2-PIX_W){1'b0}}, regs.center_x}) + (QW+2)'(sqy);
  assign sum_y = $signed({{(QW+2-PIX_W){1'b0}}, regs.center_y}) - (QW+2)'(sqz);

  always_comb begin
    satx = 1'b1;
    saty = 1'b1;
    if (qy[QW-1]) begin
      sx_next = fl.neg_y ? SCR_W'(SCR_MIN) : SCR_W'(SCR_MAX);
    end else if (sum_x > (QW+2)'(SCR_MAX)) begin
      sx_next = SCR_W'(SCR_MAX);
    end else if (sum_x < (QW+2)'(SCR_MIN)) begin
      sx_next = SCR_W'(SCR_MIN);
    end else begin
      sx_next = sum_x[SCR_W-1:0];
      satx    = 1'b0;
    end
    if (qz[QW-1]) begin
      sy_next = fl.neg_z ? SCR_W'(SCR_MAX) : SCR_W'(SCR_MIN);
    end else if (sum_y > (QW+2)'(SCR_MAX)) begin
      sy_next = SCR_W'(SCR_MAX);
    end else if (sum_y < (QW+2)'(SCR_MIN)) begin
      sy_next = SCR_W'(SCR_MIN);
    end else begin
      sy_next = sum_y[SCR_W-1:0];
      saty    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen.valid <= 1'b0;
    end else if (out_go) begin
      screen.valid <= cv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (out_go && cv[QW]) begin
      if (fl.behind) begin
        screen.screen_x   <= SCR_W'(regs.center_x);
        screen.screen_y   <= SCR_W'(regs.center_y);
        screen.behind_eye <= 1'b1;
        screen.saturated  <= 1'b0;
      end else begin
        screen.screen_x   <= sx_next;
        screen.screen_y   <= sy_next;
        screen.behind_eye <= 1'b0;
        screen.saturated  <= satx || saty;
      end
    end
  end

endmodule

@@ sv/rpp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for rotate_project_point and the bind that attaches them.
// Depends on the top level's interface ports only.
module rpp_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] screen_x,
  input logic signed [15:0] screen_y,
  input logic               behind_eye,
  input logic               saturated
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y)
      && $stable(behind_eye) && $stable(saturated))
    else $error("result changed while stalled");

  a_behind_nosat: assert property (@(posedge clk) disable iff (rst)
    out_valid && behind_eye |-> !saturated)
    else $error("behind-eye result flagged as clamped");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (screen_x == 16'sh7fff || screen_x == 16'sh8000
      || screen_y == 16'sh7fff || screen_y == 16'sh8000))
    else $error("clamp flag without a coordinate at a rail");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rotate_project_point rpp_checker u_rpp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (screen.valid),
  .out_ready  (screen.ready),
  .screen_x   (screen.screen_x),
  .screen_y   (screen.screen_y),
  .behind_eye (screen.behind_eye),
  .saturated  (screen.saturated)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench for rotate_project_point: drives points and register writes and
// checks each screen result against an in-bench projection predictor.
// Depends on rpp_pkg, rpp_ifs and the rotate_project_point RTL.
module tb;
  import rpp_pkg::*;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               behind;
    logic               sat;
  } screen_exp_t;

  class projection_scoreboard;
    longint sin_a, cos_a, sin_b, cos_b;
    longint cen_x, cen_y, focal, eye;
    screen_exp_t expected_screens[$];
    int errors;

    function new();
      sin_a = RST_SIN;
      cos_a = RST_COS;
      sin_b = RST_SIN;
      cos_b = RST_COS;
      cen_x = RST_CENTER_X;
      cen_y = RST_CENTER_Y;
      focal = RST_FOCAL;
      eye   = RST_EYE;
      errors = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        REG_SIN_A:    sin_a = longint'($signed(data));
        REG_COS_A:    cos_a = longint'($signed(data));
        REG_SIN_B:    sin_b = longint'($signed(data));
        REG_COS_B:    cos_b = longint'($signed(data));
        REG_CENTER_X: cen_x = longint'(data[PIX_W-1:0]);
        REG_CENTER_Y: cen_y = longint'(data[PIX_W-1:0]);
        REG_FOCAL:    focal = longint'(data[PIX_W-1:0]);
        REG_EYE:      eye   = longint'(data[PIX_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, inout logic sat);
      if (v > SCR_MAX) begin
        sat = 1'b1;
        return SCR_MAX;
      end
      if (v < SCR_MIN) begin
        sat = 1'b1;
        return SCR_MIN;
      end
      return v;
    endfunction

    function void note_point(logic signed [17:0] x, logic signed [17:0] y,
                             logic signed [17:0] z);
      longint px, py, pz, x1, y1, x2, z2, y2, den, sx, sy;
      screen_exp_t e;
      px = x;
      py = y;
      pz = z;
      x1 = px * cos_a + py * sin_a;
      y1 = py * cos_a - px * sin_a;
      z2 = (pz <<< 14) * cos_b + x1 * sin_b;
      x2 = x1 * cos_b - (pz <<< 14) * sin_b;
      y2 = y1 <<< 14;
      den = (eye <<< (8 + 28)) - x2;
      e.sat = 1'b0;
      e.behind = 1'b0;
      if (den <= 0) begin
        e.behind = 1'b1;
        sx = cen_x;
        sy = cen_y;
      end else begin
        sx = clamp(cen_x + (focal * y2) / den, e.sat);
        sy = clamp(cen_y - (focal * z2) / den, e.sat);
      end
      e.sx = sx[15:0];
      e.sy = sy[15:0];
      expected_screens.push_back(e);
    endfunction

    function void check_screen(logic signed [15:0] sx, logic signed [15:0] sy,
                               logic behind, logic sat);
      screen_exp_t e;
      if (expected_screens.size() == 0) begin
        $error("screen transaction with no point pending");
        errors++;
        return;
      end
      e = expected_screens.pop_front();
      if (sx !== e.sx) begin
        $error("screen_x expected %0d actual %0d", e.sx, sx);
        errors++;
      end
      if (sy !== e.sy) begin
        $error("screen_y expected %0d actual %0d", e.sy, sy);
        errors++;
      end
      if (behind !== e.behind) begin
        $error("behind_eye expected %0b actual %0b", e.behind, behind);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated expected %0b actual %0b", e.sat, sat);
        errors++;
      end
    endfunction

    function int pending();
      return expected_screens.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  rpp_point_if  point();
  rpp_screen_if screen();
  rpp_cfg_if    cfg();

  rotate_project_point dut (
    .clk    (clk),
    .rst    (rst),
    .point  (point),
    .screen (screen),
    .cfg    (cfg)
  );

  projection_scoreboard sb = new();
  int burst_left = 0;
  bit no_gaps = 0;
  int stall_mode = 0;
  int stall_cnt = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // monitors: sample at the edge, before any update of this step lands
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
      if (point.valid && point.ready) sb.note_point(point.pos_x, point.pos_y, point.pos_z);
      if (screen.valid && screen.ready)
        sb.check_screen(screen.screen_x, screen.screen_y, screen.behind_eye,
                        screen.saturated);
    end
  end

  // result stall pattern, switching at random among four modes
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 200 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: screen.ready <= 1'b1;
      1: screen.ready <= ($urandom_range(0, 3) != 0);
      2: screen.ready <= ($urandom_range(0, 3) == 0);
      default: screen.ready <= (stall_cnt % 7) >= 3;
    endcase
  end

  task automatic send_point(logic signed [17:0] x, logic signed [17:0] y,
                            logic signed [17:0] z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        point.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    point.valid <= 1'b1;
    point.pos_x <= x;
    point.pos_y <= y;
    point.pos_z <= z;
    @(posedge clk);
    while (!point.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    point.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_cfg(logic [IDX_W-1:0] idx, logic [15:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] sa, logic [15:0] ca, logic [15:0] sb_v,
                          logic [15:0] cb, logic [11:0] cx, logic [11:0] cy,
                          logic [11:0] fl, logic [11:0] ed);
    // junk in the unused top bits of the 12-bit registers must be dropped
    write_cfg(REG_SIN_A, sa);
    write_cfg(REG_COS_A, ca);
    write_cfg(REG_SIN_B, sb_v);
    write_cfg(REG_COS_B, cb);
    write_cfg(REG_CENTER_X, {4'($urandom), cx});
    write_cfg(REG_CENTER_Y, {4'($urandom), cy});
    write_cfg(REG_FOCAL, {4'($urandom), fl});
    write_cfg(REG_EYE, {4'($urandom), ed});
    cfg.valid <= 1'b0;
  endtask

  task automatic random_regs();
    real a, b;
    a = $urandom_range(0, 6283) / 1000.0;
    b = $urandom_range(0, 6283) / 1000.0;
    if ($urandom_range(0, 3) == 0)
      set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    else
      set_regs(16'($rtoi($sin(a) * 16384.0)), 16'($rtoi($cos(a) * 16384.0)),
               16'($rtoi($sin(b) * 16384.0)), 16'($rtoi($cos(b) * 16384.0)),
               12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
               12'($urandom_range(1, 4095)),
               ($urandom_range(0, 1) == 1) ? 12'($urandom_range(1, 600))
                                           : 12'($urandom_range(1, 4095)));
  endtask

  task automatic random_point();
    int r;
    int lim;
    r = $urandom_range(0, 3);
    if (r == 0) begin
      send_point(18'($urandom), 18'($urandom), 18'($urandom));
    end else begin
      lim = (r == 1) ? 131071 : 4096;
      send_point(18'($signed($urandom_range(0, 2 * lim)) - lim),
                 18'($signed($urandom_range(0, 2 * lim)) - lim),
                 18'($signed($urandom_range(0, 2 * lim)) - lim));
    end
  endtask

  initial begin
    rst = 1'b1;
    point.valid = 1'b0;
    point.pos_x = '0;
    point.pos_y = '0;
    point.pos_z = '0;
    screen.ready = 1'b1;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: field extremes
    send_point(18'sd0, 18'sd0, 18'sd0);
    send_point(18'sd131071, 18'sd0, 18'sd0);
    send_point(-18'sd131072, 18'sd0, 18'sd0);
    send_point(18'sd0, 18'sd131071, 18'sd0);
    send_point(18'sd0, -18'sd131072, 18'sd0);
    send_point(18'sd0, 18'sd0, 18'sd131071);
    send_point(18'sd0, 18'sd0, -18'sd131072);
    send_point(-18'sd131072, 18'sd131071, -18'sd131072);
    wait_idle();

    // identity rotation, eye at 100: depth right at, just in front, just behind
    set_regs(16'd0, 16'd16384, 16'd0, 16'd16384, 12'd320, 12'd240, 12'd1000, 12'd100);
    send_point(18'sd25600, 18'sd100, 18'sd100);
    send_point(18'sd25599, 18'sd100, -18'sd100);
    send_point(18'sd25601, 18'sd0, 18'sd0);
    send_point(18'sd25599, 18'sd131071, -18'sd131072);
    send_point(18'sd131071, -18'sd131072, 18'sd131071);
    send_point(18'sd25500, 18'sd5000, 18'sd5000);
    wait_idle();

    // range extremes, then values outside the nominal range
    set_regs(16'd16384, 16'd0, -16'sd16384, 16'd0, 12'd0, 12'd4095, 12'd4095, 12'd1);
    send_point(18'sd131071, 18'sd131071, 18'sd131071);
    send_point(-18'sd131072, -18'sd131072, -18'sd131072);
    send_point(18'sd1, -18'sd1, 18'sd1);
    wait_idle();
    set_regs(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 12'd4095, 12'd0, 12'd0, 12'd4095);
    send_point(18'sd131071, -18'sd131072, 18'sd131071);
    send_point(-18'sd131072, 18'sd131071, 18'sd0);
    send_point(18'sd300, 18'sd300, -18'sd300);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      random_regs();
      no_gaps = (ph % 3 == 1);
      for (int i = 0; i < 205; i++) begin
        random_point();
        if (ph == 4 && i == 100) begin
          // drain fully mid-phase, then resume
          point.valid <= 1'b0;
          @(posedge clk);
          while (sb.pending() > 0) @(posedge clk);
        end
      end
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[rotate_project_point] OK");
    else
      $display("[rotate_project_point] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[rotate_project_point] ERROR");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/rpp_pkg.sv
sv/rpp_ifs.sv
sv/rpp_rotate.sv
sv/rpp_div_cell.sv
sv/rotate_project_point.sv
sv/rpp_checker.sv
tb/tb.sv
